// File: hdl/stq_pkg.sv
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    localparam int NUM_SLOTS   = 16;
    localparam int CAPACITY    = (QUEUE_DEPTH < NUM_SLOTS) ? QUEUE_DEPTH : NUM_SLOTS;

    localparam int SLOT_BITS = 4;
    localparam int TMO_BITS  = 32;
    localparam int TAG_BITS  = 16;

    localparam logic OPC_TICK   = 1'b0;
    localparam logic OPC_INSERT = 1'b1;

    localparam logic [TMO_BITS-1:0] FOREVER_TMO = '1;

    typedef struct packed {
        logic                 valid;
        logic [TIME_BITS-1:0] deadline;
        logic [SLOT_BITS-1:0] owner;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_DROP   = 2'd1,
        OP_INSERT = 2'd2,
        OP_POP    = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [SLOT_BITS-1:0] slot;
        logic [TIME_BITS-1:0] deadline;
    } t_cell_cmd;

endpackage

// File: hdl/stq_cell.sv
module stq_cell
    import stq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    input  logic      i_hit,
    input  logic      i_after,
    output logic      o_hit,
    output logic      o_after,
    output t_entry    o_entry
);

    t_entry r_ent;
    t_entry n_ent;
    logic   w_hit_here;
    logic   w_after_here;

    assign w_hit_here   = r_ent.valid && (r_ent.owner == i_cmd.slot);
    assign w_after_here = r_ent.valid && !(i_cmd.deadline < r_ent.deadline);
    assign o_hit        = i_hit || w_hit_here;
    assign o_after      = i_after && w_after_here;
    assign o_entry      = r_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_cmd.op)
            OP_HOLD: begin
                n_ent = r_ent;
            end
            OP_DROP: begin
                if (o_hit) begin
                    n_ent = i_next;
                end
            end
            OP_INSERT: begin
                if (o_after) begin
                    n_ent = r_ent;
                end else if (i_after) begin
                    n_ent.valid    = 1'b1;
                    n_ent.deadline = i_cmd.deadline;
                    n_ent.owner    = i_cmd.slot;
                end else begin
                    n_ent = i_prev;
                end
            end
            OP_POP: begin
                n_ent = i_next;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent <= n_ent;
        end
    end

endmodule

// File: hdl/stq_chain.sv
module stq_chain
    import stq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    output t_entry    o_head,
    output logic      o_full
);

    t_entry w_ent   [0:CAPACITY];
    t_entry w_prev  [0:CAPACITY-1];
    logic   w_hit   [0:CAPACITY];
    logic   w_after [0:CAPACITY];

    assign w_ent[CAPACITY] = '0;
    assign w_hit[0]        = 1'b0;
    assign w_after[0]      = 1'b1;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_prev[g] = '0;
            end else begin : g_rest
                assign w_prev[g] = w_ent[g-1];
            end
            stq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (i_cmd),
                .i_prev  (w_prev[g]),
                .i_next  (w_ent[g+1]),
                .i_hit   (w_hit[g]),
                .i_after (w_after[g]),
                .o_hit   (w_hit[g+1]),
                .o_after (w_after[g+1]),
                .o_entry (w_ent[g])
            );
        end
    endgenerate

    assign o_head = w_ent[0];
    assign o_full = w_ent[CAPACITY-1].valid;

endmodule

// File: hdl/sorted_timer_event_queue_core.sv
// Sorted timer event queue.
// Input channel (i_in_valid / o_in_ready) takes one request per handshake:
// opcode 1 inserts an event for a slot with deadline now + timeout (all-ones
// timeout stores tag and notify but queues nothing, and a pending slot is
// replaced); opcode 0 is one tick, which advances the time and expires every
// head entry whose deadline is not later than the new time.
// Output channel (o_out_valid / i_out_ready) carries one report per expired
// event with notify set, in queue order, o_last marking the final one of a tick.
// Sequence: an insert steps through accept, removal of the old entry and
// sorted insert. A tick is accepted, then expired entries shift off the chain
// head one per cycle, save where expiry holds as below, and the last report
// moves on to the output register. Requests are taken only between items.
// Reports wait in a hold and an output register; when the receiver stalls,
// expiry holds at the next notifying entry until the output register frees up.
// Reset (synchronous, active low) empties the queue, clears the time to zero
// and drops any report not yet taken. Slot tags are valid only once written.
module sorted_timer_event_queue_core
    import stq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [SLOT_BITS-1:0] i_event_slot,
    input  logic [TMO_BITS-1:0]  i_timeout,
    input  logic                 i_notify,
    input  logic [TAG_BITS-1:0]  i_tag,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SLOT_BITS-1:0] o_fired_slot,
    output logic [TAG_BITS-1:0]  o_fired_tag,
    output logic                 o_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DROP = 4'b0010,
        S_INS  = 4'b0100,
        S_POP  = 4'b1000
    } t_state;

    t_state               r_state,     n_state;
    logic [TIME_BITS-1:0] r_time,      n_time;
    logic [SLOT_BITS-1:0] r_key_slot,  n_key_slot;
    logic [TIME_BITS-1:0] r_key_dl,    n_key_dl;
    logic                 r_forever,   n_forever;
    logic                 r_hold_valid, n_hold_valid;
    logic [SLOT_BITS-1:0] r_hold_slot, n_hold_slot;
    logic [TAG_BITS-1:0]  r_hold_tag,  n_hold_tag;
    logic                 r_out_valid, n_out_valid;
    logic [SLOT_BITS-1:0] r_out_slot,  n_out_slot;
    logic [TAG_BITS-1:0]  r_out_tag,   n_out_tag;
    logic                 r_out_last,  n_out_last;

    logic [TAG_BITS-1:0]  r_tag [0:NUM_SLOTS-1];
    logic                 r_ntf [0:NUM_SLOTS-1];

    t_cell_cmd w_cmd;
    t_entry    w_head;
    logic      w_full;
    logic      w_in_acc;
    logic      w_out_free;
    logic      w_expire;
    logic      w_head_ntf;
    logic [TAG_BITS-1:0] w_head_tag;

    stq_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_head  (w_head),
        .o_full  (w_full)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_expire     = w_head.valid && !(w_head.deadline > r_time);
    assign w_head_ntf   = r_ntf[w_head.owner];
    assign w_head_tag   = r_tag[w_head.owner];

    assign o_out_valid  = r_out_valid;
    assign o_fired_slot = r_out_slot;
    assign o_fired_tag  = r_out_tag;
    assign o_last       = r_out_last;

    always_comb begin
        n_state        = r_state;
        n_time         = r_time;
        n_key_slot     = r_key_slot;
        n_key_dl       = r_key_dl;
        n_forever      = r_forever;
        n_hold_valid   = r_hold_valid;
        n_hold_slot    = r_hold_slot;
        n_hold_tag     = r_hold_tag;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_slot     = r_out_slot;
        n_out_tag      = r_out_tag;
        n_out_last     = r_out_last;
        w_cmd.op       = OP_HOLD;
        w_cmd.slot     = r_key_slot;
        w_cmd.deadline = r_key_dl;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_opcode == OPC_INSERT) begin
                        n_key_slot = i_event_slot;
                        n_key_dl   = r_time + TIME_BITS'(i_timeout);
                        n_forever  = (i_timeout == FOREVER_TMO);
                        n_state    = S_DROP;
                    end else begin
                        n_time  = r_time + TIME_BITS'(1);
                        n_state = S_POP;
                    end
                end
            end
            S_DROP: begin
                w_cmd.op = OP_DROP;
                n_state  = r_forever ? S_IDLE : S_INS;
            end
            S_INS: begin
                if (!w_full) begin
                    w_cmd.op = OP_INSERT;
                end
                n_state = S_IDLE;
            end
            S_POP: begin
                if (w_expire) begin
                    if (!w_head_ntf) begin
                        w_cmd.op = OP_POP;
                    end else if (!r_hold_valid) begin
                        w_cmd.op     = OP_POP;
                        n_hold_valid = 1'b1;
                        n_hold_slot  = w_head.owner;
                        n_hold_tag   = w_head_tag;
                    end else if (w_out_free) begin
                        w_cmd.op    = OP_POP;
                        n_out_valid = 1'b1;
                        n_out_slot  = r_hold_slot;
                        n_out_tag   = r_hold_tag;
                        n_out_last  = 1'b0;
                        n_hold_slot = w_head.owner;
                        n_hold_tag  = w_head_tag;
                    end
                end else if (r_hold_valid) begin
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_slot   = r_hold_slot;
                        n_out_tag    = r_hold_tag;
                        n_out_last   = 1'b1;
                        n_hold_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_time       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_time       <= n_time;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_slot  <= n_key_slot;
        r_key_dl    <= n_key_dl;
        r_forever   <= n_forever;
        r_hold_slot <= n_hold_slot;
        r_hold_tag  <= n_hold_tag;
        r_out_slot  <= n_out_slot;
        r_out_tag   <= n_out_tag;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_opcode == OPC_INSERT)) begin
            r_tag[i_event_slot] <= i_tag;
            r_ntf[i_event_slot] <= i_notify;
        end
    end

endmodule

// File: hdl/stq_chk.sv
module stq_chk
    import stq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [SLOT_BITS-1:0] o_fired_slot,
    input logic [TAG_BITS-1:0]  o_fired_tag,
    input logic                 o_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("report visible after reset");

    a_one_request_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while one is in progress");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("report dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_fired_slot) && $stable(o_fired_tag) && $stable(o_last))
        else $error("report payload changed while stalled");

endmodule

bind sorted_timer_event_queue_core stq_chk u_stq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_fired_slot (o_fired_slot),
    .o_fired_tag  (o_fired_tag),
    .o_last       (o_last)
);

// File: tb/sv/tb_top.sv
module tb_top;
    import stq_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [TAG_BITS-1:0]  tag;
        logic                 last;
    } t_fire_report;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 i_opcode     = OPC_TICK;
    logic [SLOT_BITS-1:0] i_event_slot = '0;
    logic [TMO_BITS-1:0]  i_timeout    = '0;
    logic                 i_notify     = 1'b0;
    logic [TAG_BITS-1:0]  i_tag        = '0;
    logic                 i_out_ready  = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [SLOT_BITS-1:0] o_fired_slot;
    logic [TAG_BITS-1:0]  o_fired_tag;
    logic                 o_last;

    logic [TIME_BITS-1:0] now_ticks;
    logic [TIME_BITS-1:0] q_deadline [NUM_SLOTS];
    logic [SLOT_BITS-1:0] q_slot     [NUM_SLOTS];
    int                   q_len;
    logic [TAG_BITS-1:0]  tag_of     [NUM_SLOTS];
    logic                 notify_of  [NUM_SLOTS];
    logic                 pending    [NUM_SLOTS];
    t_fire_report         fired_expect [$];

    int   errors        = 0;
    int   requests_sent = 0;
    int   ticks_sent    = 0;
    int   reports_seen  = 0;
    int   idle_cycles   = 0;
    bit   in_pacing     = 1'b1;
    bit   out_pacing    = 1'b1;
    bit   hold_request  = 1'b0;

    sorted_timer_event_queue_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_event_slot (i_event_slot),
        .i_timeout    (i_timeout),
        .i_notify     (i_notify),
        .i_tag        (i_tag),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_fired_slot (o_fired_slot),
        .o_fired_tag  (o_fired_tag),
        .o_last       (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return $urandom_range(10, 30);
        end else if (r < 35) begin
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    task automatic unlink_entry(input int pos);
        int i;
        for (i = pos; i + 1 < q_len; i++) begin
            q_deadline[i] = q_deadline[i + 1];
            q_slot[i]     = q_slot[i + 1];
        end
        q_len--;
    endtask

    task automatic advance_timer_queue(input logic op, input logic [SLOT_BITS-1:0] slot,
                                       input logic [TMO_BITS-1:0] tmo, input logic ntf,
                                       input logic [TAG_BITS-1:0] tag);
        int                   pos;
        int                   i;
        logic [TIME_BITS-1:0] dl;
        logic [SLOT_BITS-1:0] s;
        t_fire_report         rep;
        t_fire_report         batch [$];
        if (op == OPC_INSERT) begin
            notify_of[slot] = ntf;
            tag_of[slot]    = tag;
            if (pending[slot]) begin
                pos = -1;
                for (i = 0; i < q_len; i++) begin
                    if (pos < 0 && q_slot[i] == slot) pos = i;
                end
                if (pos >= 0) unlink_entry(pos);
                pending[slot] = 1'b0;
            end
            if (tmo != FOREVER_TMO && q_len < CAPACITY) begin
                dl  = now_ticks + TIME_BITS'(tmo);
                pos = 0;
                while (pos < q_len && !(dl < q_deadline[pos])) pos++;
                for (i = q_len; i > pos; i--) begin
                    q_deadline[i] = q_deadline[i - 1];
                    q_slot[i]     = q_slot[i - 1];
                end
                q_deadline[pos] = dl;
                q_slot[pos]     = slot;
                q_len++;
                pending[slot] = 1'b1;
            end
        end else begin
            now_ticks = now_ticks + 1'b1;
            while (q_len > 0 && !(q_deadline[0] > now_ticks)) begin
                s = q_slot[0];
                unlink_entry(0);
                pending[s] = 1'b0;
                if (notify_of[s]) begin
                    rep.slot = s;
                    rep.tag  = tag_of[s];
                    rep.last = 1'b0;
                    batch.push_back(rep);
                end
            end
            for (i = 0; i < batch.size(); i++) begin
                rep      = batch[i];
                rep.last = (i == batch.size() - 1);
                fired_expect.push_back(rep);
            end
        end
    endtask

    initial begin
        now_ticks = '0;
        q_len     = 0;
        for (int i = 0; i < NUM_SLOTS; i++) pending[i] = 1'b0;
    end

    always @(posedge i_clk) begin : report_check
        t_fire_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            reports_seen++;
            if (fired_expect.size() == 0) begin
                $display("%0t: unexpected report: expected none, got slot %0d tag %h last %b",
                         $time, o_fired_slot, o_fired_tag, o_last);
                errors++;
            end else begin
                want = fired_expect.pop_front();
                if (o_fired_slot !== want.slot) begin
                    $display("%0t: fired_slot expected %0d got %0d",
                             $time, want.slot, o_fired_slot);
                    errors++;
                end
                if (o_fired_tag !== want.tag) begin
                    $display("%0t: fired_tag expected %h got %h", $time, want.tag, o_fired_tag);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %b got %b", $time, want.last, o_last);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            advance_timer_queue(i_opcode, i_event_slot, i_timeout, i_notify, i_tag);
        end
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
    end

    initial begin : report_sink
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (out_pacing && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no handshake for %0d cycles, %0d reports still expected",
                 $time, STALL_LIMIT, fired_expect.size());
        $display("Mismatches found");
        $finish;
    end

    task automatic send_request(input logic op, input logic [SLOT_BITS-1:0] slot,
                                input logic [TMO_BITS-1:0] tmo, input logic ntf,
                                input logic [TAG_BITS-1:0] tag);
        int gap;
        gap = in_pacing ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_event_slot <= slot;
        i_timeout    <= tmo;
        i_notify     <= ntf;
        i_tag        <= tag;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests_sent++;
        if (op == OPC_TICK) ticks_sent++;
    endtask

    task automatic test_basic_expiry();
        send_request(OPC_INSERT, 4'd0, 32'd0, 1'b1, 16'h0000);
        send_request(OPC_INSERT, 4'd15, 32'd1, 1'b1, 16'hFFFF);
        send_request(OPC_INSERT, 4'd7, 32'd0, 1'b0, 16'h1234);
        send_request(OPC_TICK, 4'd0, 32'd0, 1'b0, 16'h0000);
        send_request(OPC_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    endtask

    task automatic test_replace_and_never();
        send_request(OPC_INSERT, 4'd3, 32'd5, 1'b1, 16'hA5A5);
        send_request(OPC_INSERT, 4'd3, 32'd1, 1'b1, 16'h5A5A);
        send_request(OPC_INSERT, 4'd4, 32'd1, 1'b1, 16'h0C0C);
        send_request(OPC_INSERT, 4'd4, FOREVER_TMO, 1'b1, 16'h0D0D);
        send_request(OPC_INSERT, 4'd5, FOREVER_TMO, 1'b1, 16'h0E0E);
        send_request(OPC_TICK, 4'd0, 32'd0, 1'b0, 16'h0000);
        send_request(OPC_TICK, 4'd0, 32'd0, 1'b0, 16'h0000);
    endtask

    task automatic test_wrapped_deadline();
        send_request(OPC_INSERT, 4'd9, 32'hFFFF_FFFE, 1'b1, 16'h9999);
        send_request(OPC_INSERT, 4'd10, 32'h8000_0000, 1'b1, 16'h1010);
        send_request(OPC_INSERT, 4'd11, 32'd0, 1'b0, 16'h1111);
        send_request(OPC_TICK, 4'd0, 32'd0, 1'b0, 16'h0000);
        send_request(OPC_INSERT, 4'd12, 32'd0, 1'b0, 16'h1212);
        send_request(OPC_TICK, 4'd0, 32'd0, 1'b0, 16'h0000);
    endtask

    task automatic test_random_mix();
        int          n;
        int          r;
        logic [31:0] bits;
        logic [31:0] tmo;
        n = 0;
        while (n < 130) begin
            in_pacing  = ((n / 40) % 2) == 0;
            out_pacing = (((n + 20) / 40) % 2) == 0;
            bits = $urandom;
            if ($urandom_range(0, 99) < 55) begin
                send_request(OPC_TICK, bits[3:0], $urandom, bits[4], bits[31:16]);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    tmo = bits % 13;
                end else if (r < 75) begin
                    tmo = FOREVER_TMO;
                end else if (r < 87) begin
                    tmo = bits % 41;
                end else begin
                    tmo = $urandom;
                end
                send_request(OPC_INSERT, bits[7:4], tmo, $urandom_range(0, 99) < 80,
                             bits[31:16]);
            end
            n++;
        end
    endtask

    task automatic test_full_burst_under_hold();
        logic [31:0] bits;
        in_pacing  = 1'b0;
        out_pacing = 1'b1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            bits = $urandom;
            send_request(OPC_INSERT, i[SLOT_BITS-1:0], 32'd0, 1'b1, bits[15:0]);
        end
        // stall the receiver while ticks keep coming
        hold_request = 1'b1;
        repeat (6) send_request(OPC_TICK, 4'd0, 32'd0, 1'b0, 16'h0000);
    endtask

    initial begin : main
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_expiry();
        test_replace_and_never();
        test_wrapped_deadline();
        test_random_mix();
        test_full_burst_under_hold();
        i_in_valid <= 1'b0;
        while (fired_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests (%0d ticks), checked %0d expiry reports;",
                 requests_sent, ticks_sent, reports_seen);
        $display("covered replacement, never-expiring and wrapped deadlines, full-queue burst.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
